/* src/fsa_pkg.sv */
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants of the free list slot allocator
// Index and count widths, item codes, link memory request and controller
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package fsa_pkg;

    // pool geometry, fixed by the 10-bit slot index
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int POOL_DEPTH   = 1 << IDX_W;
    localparam int FIRST_USABLE = 1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam idx_t NULL_LINK = '0;
    localparam cnt_t COUNT_MAX = '1;
    localparam cnt_t COUNT_MIN = '0;

    // item kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DEPLETED = 1'b1;

    // one access of the link memory
    typedef struct packed {
        logic we;
        idx_t waddr;
        idx_t wdata;
        logic re;
        idx_t raddr;
    } mem_req_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_POP_WAIT
    } fsa_state_t;

endpackage

`default_nettype wire

/* src/fsa_link_mem.sv */
// ----------------------------------------------------------------------------
// fsa_link_mem: link memory of the free list
// One write port and one synchronous read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fsa_link_mem
    import fsa_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output      idx_t     rdata
);

    idx_t link_mem [POOL_DEPTH];
    idx_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            link_mem[req.waddr] <= req.wdata;
        end
    end

    // read port, read data registered
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= link_mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/fsa_ctrl.sv */
// ----------------------------------------------------------------------------
// fsa_ctrl: allocator control
// Holds list head, bump pointer and list count, decides each item and
// drives the link memory; a pop waits in ST_POP_WAIT for the next link.
// ----------------------------------------------------------------------------
`default_nettype none

module fsa_ctrl
    import fsa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     kind,
    input  wire idx_t     free_index,
    input  wire cnt_t     slot_limit,
    input  wire idx_t     link_rdata,
    output      mem_req_t mem_req,
    output      logic     busy,
    output      logic     done,
    output      idx_t     slot_index,
    output      logic     status,
    output      cnt_t     free_count
);

    fsa_state_t state_reg, state_next;
    idx_t       head_reg, head_next;
    cnt_t       bump_reg, bump_next;
    cnt_t       count_reg, count_next;
    logic       done_reg, done_next;
    idx_t       slot_reg, slot_next;
    logic       status_reg, status_next;

    logic accept;
    cnt_t limit_eff;

    assign accept = start && (state_reg == ST_IDLE);

    // bump limit clipped to the pool
    assign limit_eff = (slot_limit < cnt_t'(POOL_DEPTH)) ? slot_limit : cnt_t'(POOL_DEPTH);

    // state and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= NULL_LINK;
            bump_reg   <= cnt_t'(FIRST_USABLE);
            count_reg  <= COUNT_MIN;
            done_reg   <= 1'b0;
            slot_reg   <= NULL_LINK;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            bump_reg   <= bump_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            slot_reg   <= slot_next;
            status_reg <= status_next;
        end
    end

    // next state and memory requests
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        bump_next   = bump_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        slot_next   = slot_reg;
        status_next = status_reg;
        mem_req     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    slot_next   = NULL_LINK;
                    status_next = STATUS_OK;
                    if (kind == KIND_FREE)
                    begin
                        // push: old head goes into the freed slot
                        if (free_index != NULL_LINK)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = free_index;
                            mem_req.wdata = head_reg;
                            head_next     = free_index;
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + cnt_t'(1);
                            end
                        end
                    end
                    else if (head_reg != NULL_LINK)
                    begin
                        // pop: fetch the next link, head follows in ST_POP_WAIT
                        slot_next     = head_reg;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = head_reg;
                        state_next    = ST_POP_WAIT;
                        if (count_reg != COUNT_MIN)
                        begin
                            count_next = count_reg - cnt_t'(1);
                        end
                    end
                    else if (bump_reg < limit_eff)
                    begin
                        // never-used slot from the bump pointer
                        slot_next = bump_reg[IDX_W-1:0];
                        bump_next = bump_reg + cnt_t'(1);
                    end
                    else
                    begin
                        status_next = STATUS_DEPLETED;
                    end
                end
            end
            ST_POP_WAIT:
            begin
                head_next  = link_rdata;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg == ST_POP_WAIT);
    assign done       = done_reg;
    assign slot_index = slot_reg;
    assign status     = status_reg;
    assign free_count = count_reg;

endmodule

`default_nettype wire

/* src/free_list_slot_allocator.sv */
// ----------------------------------------------------------------------------
// free_list_slot_allocator: slot allocator for a fixed pool of 1024 slots
// Free list kept in a link memory, with a bump pointer for fresh slots.
// ----------------------------------------------------------------------------
// Usage:
//   An item (kind, free_index) is taken at a clock edge with start high and
//   busy low. Kind 0 allocates a slot, kind 1 releases free_index.
//   Each item gives one result on slot_index, status and free_count, shown
//   for exactly one cycle with done high, in the cycle after the item is
//   taken. The receiver cannot stall; results must be taken as they come.
//   Frees, bump allocations and depleted answers leave busy low, so one item
//   can be taken every cycle while no pop is pending. An allocation popped
//   from the free list waits for the link memory read that yields the new
//   list head, which holds busy high for one cycle.
//   The user must write slot_limit through cfg_valid / cfg_ready / cfg_data
//   only while the block is idle (unenforced); cfg_ready is always high.
//   Reset empties the list, sets the bump pointer to the first usable
//   slot and the limit to 1024. The link memory is not cleared; entries
//   are only read after a free has written them.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_slot_allocator
    import fsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire logic             kind,
    input  wire logic [IDX_W-1:0] free_index,
    output      logic             done,
    output      logic [IDX_W-1:0] slot_index,
    output      logic             status,
    output      logic [CNT_W-1:0] free_count,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    cnt_t     slot_limit_reg;
    mem_req_t mem_req;
    idx_t     link_rdata;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg <= cnt_t'(POOL_DEPTH);
        end
        else if (cfg_valid && cfg_ready)
        begin
            slot_limit_reg <= cfg_data;
        end
    end

    // control
    fsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .free_index (free_index),
        .slot_limit (slot_limit_reg),
        .link_rdata (link_rdata),
        .mem_req    (mem_req),
        .busy       (busy),
        .done       (done),
        .slot_index (slot_index),
        .status     (status),
        .free_count (free_count)
    );

    // link memory
    fsa_link_mem u_link_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (link_rdata)
    );

    // every taken item gives a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("item taken without a result");

    // the pop wait lasts one cycle
    a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // busy only follows a pop, whose result is shown at the same time
    a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (done && status == STATUS_OK && slot_index != NULL_LINK))
        else $error("busy without a popped slot");

    // depleted answers carry the null index
    a_depleted_null: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_DEPLETED) |-> (slot_index == NULL_LINK))
        else $error("depleted result with a slot index");

endmodule

`default_nettype wire
